/* rtl/ijvm_pkg.sv */
// ijvm_pkg: shared sizes, opcodes, status codes and sequencer states
// for the IJVM stack machine core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ijvm_pkg;

   // store depths
   localparam int TEXT_DEPTH   = 4096;
   localparam int CONST_DEPTH  = 256;
   localparam int STACK_DEPTH  = 256;
   localparam int LOCALS_DEPTH = 1024;
   localparam int FRAME_DEPTH  = 256;

   // address and pointer widths
   localparam int TEXT_AW   = $clog2(TEXT_DEPTH);
   localparam int CONST_AW  = $clog2(CONST_DEPTH);
   localparam int STACK_AW  = $clog2(STACK_DEPTH);
   localparam int LOCALS_AW = $clog2(LOCALS_DEPTH);
   localparam int FRAME_AW  = $clog2(FRAME_DEPTH);
   localparam int SP_W      = $clog2(STACK_DEPTH + 1);
   localparam int FP_W      = $clog2(FRAME_DEPTH + 1);
   localparam int LT_W      = $clog2(LOCALS_DEPTH + 1);
   localparam int SLOT_W    = ((LT_W > 16) ? LT_W : 16) + 1;
   localparam int NEED_W    = SLOT_W + 1;

   // machine constants
   localparam int JUMP_BIAS     = 3;
   localparam int METHOD_HEADER = 4;
   localparam int FRAME_WORDS   = 2;
   localparam int FETCH_BYTES   = 5;
   localparam int HEADER_BYTES  = 4;

   // request kinds
   localparam logic [1:0] REQ_LOAD_TEXT  = 2'd0;
   localparam logic [1:0] REQ_LOAD_CONST = 2'd1;
   localparam logic [1:0] REQ_EXECUTE    = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_PROGRAM_LENGTH = 2'd0;
   localparam logic [1:0] CSR_CONSTANT_COUNT = 2'd1;

   // status codes
   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_END     = 3'd1;
   localparam logic [2:0] STATUS_ERR     = 3'd2;
   localparam logic [2:0] STATUS_STACK   = 3'd3;
   localparam logic [2:0] STATUS_CTRL    = 3'd4;
   localparam logic [2:0] STATUS_INDEX   = 3'd5;
   localparam logic [2:0] STATUS_UNKNOWN = 3'd6;

   // opcodes
   localparam logic [7:0] OPC_NOP      = 8'h00;
   localparam logic [7:0] OPC_BIPUSH   = 8'h10;
   localparam logic [7:0] OPC_LDC_W    = 8'h13;
   localparam logic [7:0] OPC_ILOAD    = 8'h15;
   localparam logic [7:0] OPC_ISTORE   = 8'h36;
   localparam logic [7:0] OPC_POP      = 8'h57;
   localparam logic [7:0] OPC_DUP      = 8'h59;
   localparam logic [7:0] OPC_SWAP     = 8'h5F;
   localparam logic [7:0] OPC_IADD     = 8'h60;
   localparam logic [7:0] OPC_ISUB     = 8'h64;
   localparam logic [7:0] OPC_IAND     = 8'h7E;
   localparam logic [7:0] OPC_IINC     = 8'h84;
   localparam logic [7:0] OPC_IFEQ     = 8'h99;
   localparam logic [7:0] OPC_IFLT     = 8'h9B;
   localparam logic [7:0] OPC_ICMPEQ   = 8'h9F;
   localparam logic [7:0] OPC_GOTO     = 8'hA7;
   localparam logic [7:0] OPC_IRETURN  = 8'hAC;
   localparam logic [7:0] OPC_IOR      = 8'hB0;
   localparam logic [7:0] OPC_INVOKE   = 8'hB6;
   localparam logic [7:0] OPC_WIDE     = 8'hC4;
   localparam logic [7:0] OPC_IN       = 8'hFC;
   localparam logic [7:0] OPC_OUT      = 8'hFD;
   localparam logic [7:0] OPC_ERR      = 8'hFE;
   localparam logic [7:0] OPC_HALT     = 8'hFF;

   // sequencer states
   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_DECODE,
      S_BINOP,
      S_SWAP,
      S_SWAP2,
      S_CMP,
      S_NEWTOP,
      S_LDC,
      S_ILOAD,
      S_IINC,
      S_INV_CONST,
      S_INV_CHECK,
      S_INV_RET,
      S_ARG,
      S_ARG_WAIT,
      S_RET_LT,
      S_RET_PC,
      S_RET_BASE,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

/* rtl/ijvm_if.sv */
// ijvm channel interfaces: request, response and register write channels
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ijvm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [11:0]        load_address;
   logic signed [31:0] load_value;
   logic [7:0]         in_char;
   logic               in_eof;
   modport source (output valid, op, load_address, load_value, in_char, in_eof, input ready);
   modport sink   (input valid, op, load_address, load_value, in_char, in_eof, output ready);
endinterface

interface ijvm_rsp_if;
   logic               valid;
   logic               ready;
   logic               out_valid;
   logic [7:0]         out_char;
   logic [15:0]        next_pc;
   logic               halted;
   logic [2:0]         status;
   logic signed [31:0] top_value;
   logic [8:0]         stack_count;
   modport source (output valid, out_valid, out_char, next_pc, halted, status, top_value,
                   stack_count, input ready);
   modport sink   (input valid, out_valid, out_char, next_pc, halted, status, top_value,
                   stack_count, output ready);
endinterface

interface ijvm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/ijvm_stack_machine_core.sv */
// ijvm_stack_machine_core: top level, sequencer around five synchronous memories
// depends on ijvm_pkg, ijvm_if (channel interfaces) and ijvm_ram
//
// Usage:
//   req_ch carries one item per beat: load a text byte, load a constant word,
//   or execute one instruction. rsp_ch returns exactly one beat per item with
//   the OUT character, next pc, halted flag, status, top of stack and depth.
//   csr_ch writes program_length (index 0) and constant_count (index 1); it is
//   always ready. Users must write it only while the core is idle; the core does not enforce this.
//   Sequence: a load item passes from idle straight to the response state. An
//   execute item fetches five text bytes through the single text read port,
//   then makes up to two stack, constant or locals memory round trips.
//   INVOKEVIRTUAL adds a constant read, a method header fetch, two frame writes
//   and a locals write per argument moved; IRETURN takes two or three frame
//   reads. One item is in flight at a time.
//   Reset: synchronous and active high; afterwards the core sweeps the locals
//   memory to zero, one word per cycle over all 1024 words, with req_ch not ready.
//   Stall: the response sits in an output register; the next request is taken
//   while it waits, and its own response waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module ijvm_stack_machine_core
   import ijvm_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   ijvm_req_if.sink   req_ch,
   ijvm_rsp_if.source rsp_ch,
   ijvm_csr_if.sink   csr_ch
);

   // sequencer and architectural registers
   state_type        state_ff, state_in;
   logic [15:0]      pc_ff, pc_in;
   logic [SP_W-1:0]  sp_ff, sp_in;
   logic [FP_W-1:0]  fp_ff, fp_in;
   logic [LT_W-1:0]  lt_ff, lt_in;
   logic [LT_W-1:0]  base_ff, base_in;
   logic             done_ff, done_in;
   logic [31:0]      top_ff, top_in;
   logic [12:0]      prog_len_ff, prog_len_in;
   logic [8:0]       const_cnt_ff, const_cnt_in;
   logic [LOCALS_AW-1:0] clr_ff, clr_in;

   // fetch engine
   logic [7:0]       opnd_ff [FETCH_BYTES];
   logic [7:0]       opnd_in [FETCH_BYTES];
   logic [31:0]      fa_ff, fa_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [2:0]       flen_ff, flen_in;
   logic             hdr_ff, hdr_in;
   logic             oob_ff, oob_in;

   // per-item scratch
   logic [2:0]       status_ff, status_in;
   logic             ov_ff, ov_in;
   logic [7:0]       oc_ff, oc_in;
   logic [7:0]       in_char_ff, in_char_in;
   logic             in_eof_ff, in_eof_in;
   logic [31:0]      a_ff, a_in;
   logic [LOCALS_AW-1:0] sa_ff, sa_in;
   logic [31:0]      k_ff, k_in;
   logic [31:0]      maddr_ff, maddr_in;
   logic [LT_W-1:0]  i_ff, i_in;
   logic [LT_W-1:0]  grow_ff, grow_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ov_ff, rsp_ov_in;
   logic [7:0]       rsp_oc_ff, rsp_oc_in;
   logic [15:0]      rsp_pc_ff, rsp_pc_in;
   logic             rsp_halt_ff, rsp_halt_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_top_ff, rsp_top_in;
   logic [8:0]       rsp_count_ff, rsp_count_in;

   // memory ports
   logic                 text_we;
   logic [TEXT_AW-1:0]   text_waddr, text_raddr;
   logic [7:0]           text_wdata, text_rdata;
   logic                 const_we;
   logic [CONST_AW-1:0]  const_waddr, const_raddr;
   logic [31:0]          const_wdata, const_rdata;
   logic                 stk_we;
   logic [STACK_AW-1:0]  stk_waddr, stk_raddr;
   logic [31:0]          stk_wdata, stk_rdata;
   logic                 loc_we;
   logic [LOCALS_AW-1:0] loc_waddr, loc_raddr;
   logic [31:0]          loc_wdata, loc_rdata;
   logic                 frm_we;
   logic [FRAME_AW-1:0]  frm_waddr, frm_raddr;
   logic [31:0]          frm_wdata, frm_rdata;

   // shared combinational terms
   logic             req_acc;
   logic             slot_free;
   logic             at_end;
   logic [31:0]      fetch_addr;
   logic [7:0]       text_byte;
   logic             sp_full;
   logic             sp_ge1, sp_ge2, sp_ge3;
   logic [7:0]       opc;
   logic [15:0]      imm16;
   logic [15:0]      br_target;
   logic             wide_op;
   logic             wide_ok;
   logic [7:0]       lkind;
   logic [15:0]      lidx;
   logic [31:0]      lk;
   logic [15:0]      lnp;
   logic [SLOT_W-1:0] slot_sum;
   logic             slot_bad;
   logic             cidx_bad;
   logic [15:0]      nargs, nloc;
   logic [NEED_W-1:0] need_sum;
   logic             inv_fault;
   logic [2:0]       inv_code;
   logic [31:0]      binop_res;
   state_type        dec_next;

   // memories
   ijvm_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text_ram (
      .clock(clock), .wr_en(text_we), .wr_addr(text_waddr), .wr_data(text_wdata),
      .rd_addr(text_raddr), .rd_data(text_rdata)
   );
   ijvm_ram #(.WIDTH(32), .DEPTH(CONST_DEPTH)) u_const_ram (
      .clock(clock), .wr_en(const_we), .wr_addr(const_waddr), .wr_data(const_wdata),
      .rd_addr(const_raddr), .rd_data(const_rdata)
   );
   ijvm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata)
   );
   ijvm_ram #(.WIDTH(32), .DEPTH(LOCALS_DEPTH)) u_locals_ram (
      .clock(clock), .wr_en(loc_we), .wr_addr(loc_waddr), .wr_data(loc_wdata),
      .rd_addr(loc_raddr), .rd_data(loc_rdata)
   );
   ijvm_ram #(.WIDTH(32), .DEPTH(FRAME_DEPTH)) u_frame_ram (
      .clock(clock), .wr_en(frm_we), .wr_addr(frm_waddr), .wr_data(frm_wdata),
      .rd_addr(frm_raddr), .rd_data(frm_rdata)
   );

   // handshakes
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && (state_ff == S_IDLE);
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign at_end       = done_ff || (pc_ff >= 16'(prog_len_ff));

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_valid   = rsp_ov_ff;
   assign rsp_ch.out_char    = rsp_oc_ff;
   assign rsp_ch.next_pc     = rsp_pc_ff;
   assign rsp_ch.halted      = rsp_halt_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.top_value   = rsp_top_ff;
   assign rsp_ch.stack_count = rsp_count_ff;

   // text fetch address, out of range bytes read as zero
   assign fetch_addr = fa_ff + 32'(cnt_ff);
   assign text_raddr = fetch_addr[TEXT_AW-1:0];
   assign oob_in     = fetch_addr >= 32'(TEXT_DEPTH);
   assign text_byte  = oob_ff ? 8'h00 : text_rdata;

   // stack depth tests
   assign sp_full = sp_ff >= SP_W'(STACK_DEPTH);
   assign sp_ge1  = sp_ff >= SP_W'(1);
   assign sp_ge2  = sp_ff >= SP_W'(2);
   assign sp_ge3  = sp_ff >= SP_W'(3);

   // instruction fields
   assign opc       = opnd_ff[0];
   assign imm16     = {opnd_ff[1], opnd_ff[2]};
   assign br_target = pc_ff + imm16;
   assign wide_op   = (opc == OPC_WIDE);
   assign wide_ok   = (opnd_ff[1] == OPC_ILOAD) || (opnd_ff[1] == OPC_ISTORE) ||
                      (opnd_ff[1] == OPC_IINC);
   assign lkind     = wide_op ? opnd_ff[1] : opc;
   assign lidx      = wide_op ? {opnd_ff[2], opnd_ff[3]} : {8'h00, opnd_ff[1]};
   assign lk        = wide_op ? {{24{opnd_ff[4][7]}}, opnd_ff[4]}
                              : {{24{opnd_ff[2][7]}}, opnd_ff[2]};
   assign lnp       = wide_op ? ((lkind == OPC_IINC) ? pc_ff + 16'd5 : pc_ff + 16'd4)
                              : ((lkind == OPC_IINC) ? pc_ff + 16'd3 : pc_ff + 16'd2);
   assign slot_sum  = SLOT_W'(base_ff) + SLOT_W'(lidx);
   assign slot_bad  = slot_sum >= SLOT_W'(LOCALS_DEPTH);
   assign cidx_bad  = (imm16 >= 16'(const_cnt_ff)) || ({1'b0, imm16} >= 17'(CONST_DEPTH));

   // method header checks, priority index then control then stack
   assign nargs    = {opnd_ff[0], opnd_ff[1]};
   assign nloc     = {opnd_ff[2], opnd_ff[3]};
   assign need_sum = NEED_W'(lt_ff) + NEED_W'(nargs) + NEED_W'(nloc);
   always_comb begin
      inv_fault = 1'b1;
      inv_code  = STATUS_OK;
      if (need_sum > NEED_W'(LOCALS_DEPTH)) begin
         inv_code = STATUS_INDEX;
      end else if ((FP_W+1)'(fp_ff) + (FP_W+1)'(FRAME_WORDS) > (FP_W+1)'(FRAME_DEPTH)) begin
         inv_code = STATUS_CTRL;
      end else if (16'(sp_ff) < nargs) begin
         inv_code = STATUS_STACK;
      end else begin
         inv_fault = 1'b0;
      end
   end

   // two-operand alu
   always_comb begin
      case (opc)
         OPC_IADD: binop_res = stk_rdata + top_ff;
         OPC_ISUB: binop_res = stk_rdata - top_ff;
         OPC_IAND: binop_res = stk_rdata & top_ff;
         default:  binop_res = stk_rdata | top_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == LOCALS_AW'(LOCALS_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               state_in = (req_ch.op == REQ_EXECUTE && !at_end) ? S_FETCH : S_RESP;
            end
         end
         S_FETCH: begin
            if (cnt_ff == flen_ff) state_in = hdr_ff ? S_INV_CHECK : S_DECODE;
         end
         S_DECODE:    state_in = dec_next;
         S_BINOP:     state_in = S_RESP;
         S_SWAP:      state_in = S_SWAP2;
         S_SWAP2:     state_in = S_RESP;
         S_CMP:       state_in = sp_ge3 ? S_NEWTOP : S_RESP;
         S_NEWTOP:    state_in = S_RESP;
         S_LDC:       state_in = S_RESP;
         S_ILOAD:     state_in = S_RESP;
         S_IINC:      state_in = S_RESP;
         S_INV_CONST: state_in = S_FETCH;
         S_INV_CHECK: state_in = inv_fault ? S_RESP : S_INV_RET;
         S_INV_RET:   state_in = S_ARG;
         S_ARG: begin
            if (i_ff == '0) state_in = S_RESP;
            else if (sp_ge2) state_in = S_ARG_WAIT;
         end
         S_ARG_WAIT:  state_in = S_ARG;
         S_RET_LT:    state_in = S_RET_PC;
         S_RET_PC:    state_in = (fp_ff >= FP_W'(2 * FRAME_WORDS)) ? S_RET_BASE : S_RESP;
         S_RET_BASE:  state_in = S_RESP;
         S_RESP: begin
            if (slot_free) state_in = S_IDLE;
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath, memory controls and register updates
   always_comb begin
      pc_in        = pc_ff;
      sp_in        = sp_ff;
      fp_in        = fp_ff;
      lt_in        = lt_ff;
      base_in      = base_ff;
      done_in      = done_ff;
      top_in       = top_ff;
      prog_len_in  = prog_len_ff;
      const_cnt_in = const_cnt_ff;
      clr_in       = clr_ff;
      opnd_in      = opnd_ff;
      fa_in        = fa_ff;
      cnt_in       = cnt_ff;
      flen_in      = flen_ff;
      hdr_in       = hdr_ff;
      status_in    = status_ff;
      ov_in        = ov_ff;
      oc_in        = oc_ff;
      in_char_in   = in_char_ff;
      in_eof_in    = in_eof_ff;
      a_in         = a_ff;
      sa_in        = sa_ff;
      k_in         = k_ff;
      maddr_in     = maddr_ff;
      i_in         = i_ff;
      grow_in      = grow_ff;
      dec_next     = S_RESP;

      rsp_valid_in  = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      rsp_ov_in     = rsp_ov_ff;
      rsp_oc_in     = rsp_oc_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_halt_in   = rsp_halt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_count_in  = rsp_count_ff;

      text_we     = 1'b0;
      text_waddr  = req_ch.load_address[TEXT_AW-1:0];
      text_wdata  = req_ch.load_value[7:0];
      const_we    = 1'b0;
      const_waddr = req_ch.load_address[CONST_AW-1:0];
      const_wdata = req_ch.load_value;
      const_raddr = imm16[CONST_AW-1:0];
      stk_we      = 1'b0;
      stk_waddr   = sp_ff[STACK_AW-1:0];
      stk_wdata   = top_ff;
      stk_raddr   = STACK_AW'(sp_ff - SP_W'(2));
      loc_we      = 1'b0;
      loc_waddr   = sa_ff;
      loc_wdata   = 32'd0;
      loc_raddr   = slot_sum[LOCALS_AW-1:0];
      frm_we      = 1'b0;
      frm_waddr   = fp_ff[FRAME_AW-1:0];
      frm_wdata   = 32'(lt_ff);
      frm_raddr   = FRAME_AW'(fp_ff - FP_W'(2));

      // register writes
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_PROGRAM_LENGTH: prog_len_in  = csr_ch.data[12:0];
            CSR_CONSTANT_COUNT: const_cnt_in = csr_ch.data[8:0];
            default: ;
         endcase
      end

      case (state_ff)
         // locals sweep after reset
         S_CLEAR: begin
            loc_we    = 1'b1;
            loc_waddr = clr_ff;
            loc_wdata = 32'd0;
            clr_in    = clr_ff + LOCALS_AW'(1);
         end

         // request beat
         S_IDLE: begin
            if (req_acc) begin
               ov_in      = 1'b0;
               oc_in      = 8'h00;
               status_in  = STATUS_OK;
               in_char_in = req_ch.in_char;
               in_eof_in  = req_ch.in_eof;
               fa_in      = {16'h0000, pc_ff};
               cnt_in     = 3'd0;
               flen_in    = 3'(FETCH_BYTES);
               hdr_in     = 1'b0;
               case (req_ch.op)
                  REQ_LOAD_TEXT: begin
                     text_we = {20'h0, req_ch.load_address} < 32'(TEXT_DEPTH);
                  end
                  REQ_LOAD_CONST: begin
                     const_we = {20'h0, req_ch.load_address} < 32'(CONST_DEPTH);
                  end
                  REQ_EXECUTE: begin
                     if (at_end) begin
                        done_in   = 1'b1;
                        status_in = STATUS_END;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // byte fetch, data lands in the cycle after its address
         S_FETCH: begin
            if (cnt_ff != flen_ff) cnt_in = cnt_ff + 3'd1;
            if (cnt_ff != 3'd0) opnd_in[cnt_ff - 3'd1] = text_byte;
         end

         S_DECODE: begin
            case (opc)
               OPC_NOP: pc_in = pc_ff + 16'd1;
               OPC_BIPUSH: begin
                  if (sp_full) begin
                     done_in = 1'b1; status_in = STATUS_STACK;
                  end else begin
                     stk_we    = 1'b1;
                     stk_wdata = {{24{opnd_ff[1][7]}}, opnd_ff[1]};
                     top_in    = stk_wdata;
                     sp_in     = sp_ff + SP_W'(1);
                     pc_in     = pc_ff + 16'd2;
                  end
               end
               OPC_DUP: begin
                  if (!sp_ge1 || sp_full) begin
                     done_in = 1'b1; status_in = STATUS_STACK;
                  end else begin
                     stk_we    = 1'b1;
                     stk_wdata = top_ff;
                     sp_in     = sp_ff + SP_W'(1);
                     pc_in     = pc_ff + 16'd1;
                  end
               end
               OPC_IADD, OPC_ISUB, OPC_IAND, OPC_IOR, OPC_SWAP, OPC_ICMPEQ: begin
                  if (!sp_ge2) begin
                     done_in = 1'b1; status_in = STATUS_STACK;
                  end else begin
                     pc_in = pc_ff + 16'd1;
                     if (opc == OPC_SWAP) dec_next = S_SWAP;
                     else if (opc == OPC_ICMPEQ) dec_next = S_CMP;
                     else dec_next = S_BINOP;
                  end
               end
               OPC_POP, OPC_OUT, OPC_IFEQ, OPC_IFLT: begin
                  if (!sp_ge1) begin
                     done_in = 1'b1; status_in = STATUS_STACK;
                  end else begin
                     sp_in    = sp_ff - SP_W'(1);
                     dec_next = sp_ge2 ? S_NEWTOP : S_RESP;
                     pc_in    = pc_ff + 16'd1;
                     if (opc == OPC_OUT) begin
                        ov_in = 1'b1;
                        oc_in = top_ff[7:0];
                     end else if (opc == OPC_IFEQ) begin
                        pc_in = (top_ff == 32'd0) ? br_target : pc_ff + 16'(JUMP_BIAS);
                     end else if (opc == OPC_IFLT) begin
                        pc_in = top_ff[31] ? br_target : pc_ff + 16'(JUMP_BIAS);
                     end
                  end
               end
               OPC_ERR: begin
                  done_in = 1'b1; status_in = STATUS_ERR; pc_in = pc_ff + 16'd1;
               end
               OPC_HALT: begin
                  done_in = 1'b1; status_in = STATUS_END; pc_in = pc_ff + 16'd1;
               end
               OPC_IN: begin
                  if (sp_full) begin
                     done_in = 1'b1; status_in = STATUS_STACK;
                  end else begin
                     stk_we    = 1'b1;
                     stk_wdata = in_eof_ff ? 32'd0 : {24'h0, in_char_ff};
                     top_in    = stk_wdata;
                     sp_in     = sp_ff + SP_W'(1);
                     pc_in     = pc_ff + 16'd1;
                  end
               end
               OPC_GOTO: pc_in = br_target;
               OPC_LDC_W: begin
                  if (cidx_bad) begin
                     done_in = 1'b1; status_in = STATUS_INDEX;
                  end else if (sp_full) begin
                     done_in = 1'b1; status_in = STATUS_STACK;
                  end else begin
                     dec_next = S_LDC;
                     pc_in    = pc_ff + 16'd3;
                  end
               end
               OPC_ILOAD, OPC_ISTORE, OPC_IINC, OPC_WIDE: begin
                  if (wide_op && !wide_ok) begin
                     done_in = 1'b1; status_in = STATUS_UNKNOWN; pc_in = pc_ff + 16'd1;
                  end else if (slot_bad) begin
                     done_in = 1'b1; status_in = STATUS_INDEX;
                  end else begin
                     sa_in = slot_sum[LOCALS_AW-1:0];
                     k_in  = lk;
                     case (lkind)
                        OPC_ILOAD: begin
                           if (sp_full) begin
                              done_in = 1'b1; status_in = STATUS_STACK;
                           end else begin
                              dec_next = S_ILOAD;
                              pc_in    = lnp;
                           end
                        end
                        OPC_ISTORE: begin
                           if (!sp_ge1) begin
                              done_in = 1'b1; status_in = STATUS_STACK;
                           end else begin
                              loc_we    = 1'b1;
                              loc_waddr = slot_sum[LOCALS_AW-1:0];
                              loc_wdata = top_ff;
                              if (slot_sum >= SLOT_W'(lt_ff)) begin
                                 lt_in = slot_sum[LT_W-1:0] + LT_W'(1);
                              end
                              sp_in    = sp_ff - SP_W'(1);
                              dec_next = sp_ge2 ? S_NEWTOP : S_RESP;
                              pc_in    = lnp;
                           end
                        end
                        default: begin
                           dec_next = S_IINC;
                           pc_in    = lnp;
                        end
                     endcase
                  end
               end
               OPC_INVOKE: begin
                  if (cidx_bad) begin
                     done_in = 1'b1; status_in = STATUS_INDEX;
                  end else begin
                     dec_next = S_INV_CONST;
                  end
               end
               OPC_IRETURN: begin
                  if (fp_ff < FP_W'(FRAME_WORDS)) begin
                     done_in = 1'b1; status_in = STATUS_CTRL;
                  end else if (!sp_ge1) begin
                     done_in = 1'b1; status_in = STATUS_STACK;
                  end else begin
                     dec_next = S_RET_LT;
                  end
               end
               default: begin
                  done_in = 1'b1; status_in = STATUS_UNKNOWN; pc_in = pc_ff + 16'd1;
               end
            endcase
         end

         // second operand has arrived
         S_BINOP: begin
            stk_we    = 1'b1;
            stk_waddr = STACK_AW'(sp_ff - SP_W'(2));
            stk_wdata = binop_res;
            top_in    = binop_res;
            sp_in     = sp_ff - SP_W'(1);
         end
         S_SWAP: begin
            stk_we    = 1'b1;
            stk_waddr = STACK_AW'(sp_ff - SP_W'(1));
            stk_wdata = stk_rdata;
            top_in    = stk_rdata;
            a_in      = top_ff;
         end
         S_SWAP2: begin
            stk_we    = 1'b1;
            stk_waddr = STACK_AW'(sp_ff - SP_W'(2));
            stk_wdata = a_ff;
         end
         S_CMP: begin
            pc_in     = (stk_rdata == top_ff) ? pc_ff - 16'd1 + imm16
                                              : pc_ff - 16'd1 + 16'(JUMP_BIAS);
            sp_in     = sp_ff - SP_W'(2);
            stk_raddr = STACK_AW'(sp_ff - SP_W'(3));
         end
         S_NEWTOP: top_in = stk_rdata;

         // pushes from constant and locals memories, and the locals increment
         S_LDC: begin
            stk_we    = 1'b1;
            stk_wdata = const_rdata;
            top_in    = const_rdata;
            sp_in     = sp_ff + SP_W'(1);
         end
         S_ILOAD: begin
            stk_we    = 1'b1;
            stk_wdata = loc_rdata;
            top_in    = loc_rdata;
            sp_in     = sp_ff + SP_W'(1);
         end
         S_IINC: begin
            loc_we    = 1'b1;
            loc_waddr = sa_ff;
            loc_wdata = loc_rdata + k_ff;
         end

         // method call
         S_INV_CONST: begin
            maddr_in = const_rdata;
            fa_in    = const_rdata;
            cnt_in   = 3'd0;
            flen_in  = 3'(HEADER_BYTES);
            hdr_in   = 1'b1;
         end
         S_INV_CHECK: begin
            if (inv_fault) begin
               done_in   = 1'b1;
               status_in = inv_code;
            end else begin
               frm_we    = 1'b1;
               frm_waddr = fp_ff[FRAME_AW-1:0];
               frm_wdata = 32'(lt_ff);
               i_in      = nargs[LT_W-1:0];
               grow_in   = LT_W'(nargs + nloc);
            end
         end
         S_INV_RET: begin
            frm_we    = 1'b1;
            frm_waddr = FRAME_AW'(fp_ff + FP_W'(1));
            frm_wdata = {16'h0000, pc_ff + 16'(JUMP_BIAS)};
            fp_in     = fp_ff + FP_W'(FRAME_WORDS);
         end
         S_ARG: begin
            if (i_ff != '0) begin
               loc_we    = 1'b1;
               loc_waddr = LOCALS_AW'(lt_ff + i_ff - LT_W'(1));
               loc_wdata = top_ff;
               sp_in     = sp_ff - SP_W'(1);
               i_in      = i_ff - LT_W'(1);
            end else begin
               lt_in   = lt_ff + grow_ff;
               base_in = lt_ff;
               pc_in   = maddr_ff[15:0] + 16'(METHOD_HEADER);
            end
         end
         S_ARG_WAIT: top_in = stk_rdata;

         // method return
         S_RET_LT: begin
            lt_in     = frm_rdata[LT_W-1:0];
            frm_raddr = FRAME_AW'(fp_ff - FP_W'(1));
         end
         S_RET_PC: begin
            pc_in     = frm_rdata[15:0];
            fp_in     = fp_ff - FP_W'(FRAME_WORDS);
            frm_raddr = FRAME_AW'(fp_ff - FP_W'(2 * FRAME_WORDS));
            if (fp_ff < FP_W'(2 * FRAME_WORDS)) base_in = '0;
         end
         S_RET_BASE: base_in = frm_rdata[LT_W-1:0];

         // response beat
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ov_in     = ov_ff;
               rsp_oc_in     = oc_ff;
               rsp_pc_in     = pc_ff;
               rsp_halt_in   = done_ff;
               rsp_status_in = status_ff;
               rsp_top_in    = (sp_ff != '0) ? top_ff : 32'd0;
               rsp_count_in  = 9'(sp_ff);
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pc_ff        <= '0;
         sp_ff        <= '0;
         fp_ff        <= '0;
         lt_ff        <= '0;
         base_ff      <= '0;
         done_ff      <= 1'b0;
         prog_len_ff  <= '0;
         const_cnt_ff <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         sp_ff        <= sp_in;
         fp_ff        <= fp_in;
         lt_ff        <= lt_in;
         base_ff      <= base_in;
         done_ff      <= done_in;
         prog_len_ff  <= prog_len_in;
         const_cnt_ff <= const_cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      opnd_ff       <= opnd_in;
      fa_ff         <= fa_in;
      cnt_ff        <= cnt_in;
      flen_ff       <= flen_in;
      hdr_ff        <= hdr_in;
      oob_ff        <= oob_in;
      status_ff     <= status_in;
      ov_ff         <= ov_in;
      oc_ff         <= oc_in;
      in_char_ff    <= in_char_in;
      in_eof_ff     <= in_eof_in;
      a_ff          <= a_in;
      sa_ff         <= sa_in;
      k_ff          <= k_in;
      maddr_ff      <= maddr_in;
      i_ff          <= i_in;
      grow_ff       <= grow_in;
      rsp_ov_ff     <= rsp_ov_in;
      rsp_oc_ff     <= rsp_oc_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_halt_ff   <= rsp_halt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

`default_nettype wire

/* rtl/ijvm_ram.sv */
// ijvm_ram: generic single-write, single-read memory with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ijvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sim/ijvm_stack_machine_core_tb.sv */
// ijvm_stack_machine_core_tb: self-checking bench for the IJVM stack machine core
// depends on ijvm_pkg, ijvm_if and the core; a scoreboard class predicts each response
`timescale 1ns / 1ps

module ijvm_stack_machine_core_tb;
   import ijvm_pkg::*;

   typedef struct {
      logic [1:0]  op;
      logic [11:0] addr;
      logic [31:0] value;
      logic [7:0]  in_char;
      logic        in_eof;
   } req_beat_t;

   typedef struct {
      logic        out_valid;
      logic [7:0]  out_char;
      logic [15:0] next_pc;
      logic        halted;
      logic [2:0]  status;
      logic [31:0] top_value;
      logic [8:0]  stack_count;
   } rsp_beat_t;

   typedef enum {
      K_NOP, K_BIPUSH, K_DUP, K_IADD, K_ISUB, K_IAND, K_IOR, K_POP, K_SWAP, K_IN, K_OUT,
      K_GOTO, K_IFEQ, K_IFLT, K_ICMPEQ, K_LDC, K_ILOAD, K_ISTORE, K_IINC,
      K_WILOAD, K_WISTORE, K_WIINC, K_INVOKE, K_IRETURN
   } instr_kind_e;

   // machine predictor plus queue of expected response beats
   class ijvm_scoreboard;
      logic [7:0]  text_mem[TEXT_DEPTH];
      bit          text_seen[TEXT_DEPTH];
      logic [31:0] const_mem[CONST_DEPTH];
      bit          const_seen[CONST_DEPTH];
      logic [31:0] opstack[STACK_DEPTH];
      logic [31:0] locals[LOCALS_DEPTH];
      logic [31:0] frames[FRAME_DEPTH];
      int unsigned pc, sp, fp, ltop, prog_len, const_cnt;
      bit          done;
      rsp_beat_t   pending[$];
      int          mismatches, checked, executed;

      function new();
         foreach (locals[i]) locals[i] = '0;
      endfunction

      function int unsigned rd8(int unsigned a);
         return (a < TEXT_DEPTH) ? int'(text_mem[a]) : 0;
      endfunction

      function int unsigned rd16(int unsigned a);
         return (rd8(a) << 8) | rd8(a + 1);
      endfunction

      function logic [31:0] sext8(int unsigned v);
         return v[7] ? (v | 32'hFFFFFF00) : v;
      endfunction

      function logic [31:0] sext16(int unsigned v);
         return v[15] ? (v | 32'hFFFF0000) : v;
      endfunction

      function void push(logic [31:0] v);
         opstack[sp] = v;
         sp++;
      endfunction

      function logic [31:0] pop();
         sp--;
         return opstack[sp];
      endfunction

      function int unsigned frame_base();
         return (fp >= FRAME_WORDS) ? int'(frames[fp - FRAME_WORDS]) : 0;
      endfunction

      function logic [2:0] fail(logic [2:0] code);
         done = 1;
         return code;
      endfunction

      // one instruction; faults leave pc on the opcode, except unknown opcodes, which step past it
      function logic [2:0] execute(logic [7:0] ch, logic eof, output logic ov,
                                   output logic [7:0] oc);
         int unsigned p, np, idx, sa, maddr, nargs, nloc;
         logic [7:0]  opc, kind, sub;
         logic [31:0] a, b, k, tgt;
         bit          take;
         ov = 0;
         oc = '0;
         if (!done && pc >= prog_len) done = 1;
         if (done) return STATUS_END;
         p = pc;
         opc = rd8(p);
         np = p + 1;
         case (opc)
            OPC_NOP: ;
            OPC_BIPUSH: begin
               if (sp >= STACK_DEPTH) return fail(STATUS_STACK);
               push(sext8(rd8(p + 1)));
               np = p + 2;
            end
            OPC_DUP: begin
               if (sp < 1 || sp >= STACK_DEPTH) return fail(STATUS_STACK);
               push(opstack[sp - 1]);
            end
            OPC_IADD, OPC_ISUB, OPC_IAND, OPC_IOR: begin
               if (sp < 2) return fail(STATUS_STACK);
               b = pop();
               a = pop();
               case (opc)
                  OPC_IADD: a = a + b;
                  OPC_ISUB: a = a - b;
                  OPC_IAND: a = a & b;
                  default:  a = a | b;
               endcase
               push(a);
            end
            OPC_POP: begin
               if (sp < 1) return fail(STATUS_STACK);
               void'(pop());
            end
            OPC_SWAP: begin
               if (sp < 2) return fail(STATUS_STACK);
               a = pop();
               b = pop();
               push(a);
               push(b);
            end
            OPC_ERR: begin
               done = 1;
               pc = np & 16'hFFFF;
               return STATUS_ERR;
            end
            OPC_HALT: begin
               done = 1;
               pc = np & 16'hFFFF;
               return STATUS_END;
            end
            OPC_IN: begin
               if (sp >= STACK_DEPTH) return fail(STATUS_STACK);
               push(eof ? 32'd0 : {24'd0, ch});
            end
            OPC_OUT: begin
               if (sp < 1) return fail(STATUS_STACK);
               a = pop();
               ov = 1;
               oc = a[7:0];
            end
            OPC_GOTO, OPC_IFEQ, OPC_IFLT, OPC_ICMPEQ: begin
               tgt = p + sext16(rd16(p + 1));
               take = 1;
               if (opc == OPC_IFEQ || opc == OPC_IFLT) begin
                  if (sp < 1) return fail(STATUS_STACK);
                  a = pop();
                  take = (opc == OPC_IFEQ) ? (a == 0) : a[31];
               end else if (opc == OPC_ICMPEQ) begin
                  if (sp < 2) return fail(STATUS_STACK);
                  b = pop();
                  a = pop();
                  take = (a == b);
               end
               np = take ? tgt : p + JUMP_BIAS;
            end
            OPC_LDC_W: begin
               idx = rd16(p + 1);
               if (idx >= const_cnt || idx >= CONST_DEPTH) return fail(STATUS_INDEX);
               if (sp >= STACK_DEPTH) return fail(STATUS_STACK);
               push(const_mem[idx]);
               np = p + 3;
            end
            OPC_ILOAD, OPC_ISTORE, OPC_IINC, OPC_WIDE: begin
               kind = opc;
               if (opc == OPC_WIDE) begin
                  sub = rd8(p + 1);
                  if (sub != OPC_ILOAD && sub != OPC_ISTORE && sub != OPC_IINC) begin
                     done = 1;
                     pc = np & 16'hFFFF;
                     return STATUS_UNKNOWN;
                  end
                  kind = sub;
                  idx = rd16(p + 2);
                  k = sext8(rd8(p + 4));
                  np = (kind == OPC_IINC) ? p + 5 : p + 4;
               end else begin
                  idx = rd8(p + 1);
                  k = sext8(rd8(p + 2));
                  np = (kind == OPC_IINC) ? p + 3 : p + 2;
               end
               if (longint'(frame_base()) + idx >= LOCALS_DEPTH) return fail(STATUS_INDEX);
               sa = frame_base() + idx;
               if (kind == OPC_ILOAD) begin
                  if (sp >= STACK_DEPTH) return fail(STATUS_STACK);
                  push(locals[sa]);
               end else if (kind == OPC_ISTORE) begin
                  if (sp < 1) return fail(STATUS_STACK);
                  locals[sa] = pop();
                  if (sa >= ltop) ltop = sa + 1;
               end else begin
                  locals[sa] = locals[sa] + k;
               end
            end
            OPC_INVOKE: begin
               idx = rd16(p + 1);
               if (idx >= const_cnt || idx >= CONST_DEPTH) return fail(STATUS_INDEX);
               maddr = const_mem[idx];
               nargs = rd16(maddr);
               nloc = rd16(maddr + 2);
               if (longint'(ltop) + nargs + nloc > LOCALS_DEPTH) return fail(STATUS_INDEX);
               if (fp + FRAME_WORDS > FRAME_DEPTH) return fail(STATUS_CTRL);
               if (sp < nargs) return fail(STATUS_STACK);
               frames[fp] = ltop;
               frames[fp + 1] = (p + 3) & 16'hFFFF;
               fp += FRAME_WORDS;
               for (int i = nargs; i > 0; i--) locals[ltop + i - 1] = pop();
               ltop += nargs + nloc;
               np = maddr + METHOD_HEADER;
            end
            OPC_IRETURN: begin
               if (fp < FRAME_WORDS) return fail(STATUS_CTRL);
               if (sp < 1) return fail(STATUS_STACK);
               a = pop();
               ltop = frames[fp - 2];
               np = frames[fp - 1];
               fp -= FRAME_WORDS;
               push(a);
            end
            default: begin
               done = 1;
               pc = np & 16'hFFFF;
               return STATUS_UNKNOWN;
            end
         endcase
         pc = np & 16'hFFFF;
         return STATUS_OK;
      endfunction

      // accepted request beat: update the machine and queue its response
      function void note_item(req_beat_t r);
         rsp_beat_t e;
         logic      ov;
         logic [7:0] oc;
         ov = 0;
         oc = '0;
         e.status = STATUS_OK;
         case (r.op)
            REQ_LOAD_TEXT: begin
               text_mem[r.addr] = r.value[7:0];
               text_seen[r.addr] = 1;
            end
            REQ_LOAD_CONST: if (r.addr < CONST_DEPTH) begin
               const_mem[r.addr] = r.value;
               const_seen[r.addr] = 1;
            end
            REQ_EXECUTE: begin
               e.status = execute(r.in_char, r.in_eof, ov, oc);
               executed++;
            end
            default: ;
         endcase
         e.out_valid = ov;
         e.out_char = oc;
         e.next_pc = pc[15:0];
         e.halted = done;
         e.top_value = (sp > 0) ? opstack[sp - 1] : 32'd0;
         e.stack_count = sp[8:0];
         pending.push_back(e);
      endfunction

      function void check_result(rsp_beat_t a);
         rsp_beat_t e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response beat with nothing expected: pc=%0d", a.next_pc);
            return;
         end
         e = pending.pop_front();
         if (a.out_valid !== e.out_valid || a.out_char !== e.out_char ||
             a.next_pc !== e.next_pc || a.halted !== e.halted || a.status !== e.status ||
             a.top_value !== e.top_value || a.stack_count !== e.stack_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch #%0d: exp ov=%0d ch=%h pc=%0d h=%0d st=%0d top=%h n=%0d, got ov=%0d ch=%h pc=%0d h=%0d st=%0d top=%h n=%0d",
                        checked, e.out_valid, e.out_char, e.next_pc, e.halted, e.status,
                        e.top_value, e.stack_count, a.out_valid, a.out_char, a.next_pc,
                        a.halted, a.status, a.top_value, a.stack_count);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ijvm_req_if req_ch ();
   ijvm_rsp_if rsp_ch ();
   ijvm_csr_if csr_ch ();

   ijvm_stack_machine_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ijvm_scoreboard sb;
   int items_sent;
   int results_seen;
   bit sender_quiet;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // give up after a generous bound
   initial begin
      #12_000_000;
      $display("Some tests failed");
      $finish;
   end

   // one request beat; valid stays high across back-to-back beats
   task automatic send(req_beat_t r);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.op <= r.op;
      req_ch.load_address <= r.addr;
      req_ch.load_value <= r.value;
      req_ch.in_char <= r.in_char;
      req_ch.in_eof <= r.in_eof;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_item(r);
      items_sent++;
      if (items_sent % 60 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
   endtask

   function automatic req_beat_t make_beat(logic [1:0] op, int unsigned addr,
                                           logic [31:0] value);
      req_beat_t r;
      r.op = op;
      r.addr = addr[11:0];
      r.value = value;
      r.in_char = $urandom_range(0, 255);
      r.in_eof = $urandom_range(0, 3) == 0;
      return r;
   endfunction

   task automatic wait_drained();
      req_ch.valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int unsigned val);
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.data <= val | ($urandom() << 13);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 0;
      if (idx == CSR_PROGRAM_LENGTH) sb.prog_len = val & 13'h1FFF;
      else sb.const_cnt = val & 9'h1FF;
   endtask

   // write instruction bytes at pc, then execute; padding bytes only if never written
   task automatic place_and_run(logic [7:0] code[$], int must);
      int unsigned p;
      p = sb.pc;
      foreach (code[i])
         if (p + i < TEXT_DEPTH && (i < must || !sb.text_seen[p + i]))
            send(make_beat(REQ_LOAD_TEXT, p + i, {$urandom_range(0, 16777215), code[i]}));
      send(make_beat(REQ_EXECUTE, $urandom_range(0, 4095), $urandom()));
   endtask

   function automatic bit can_run(instr_kind_e k);
      int unsigned sp, base;
      sp = sb.sp;
      base = sb.frame_base();
      if (sb.pc > 4080) return k == K_GOTO;
      case (k)
         K_NOP, K_GOTO:                         return 1;
         K_BIPUSH, K_IN:                        return sp < STACK_DEPTH;
         K_DUP:                                 return sp >= 1 && sp < STACK_DEPTH;
         K_IADD, K_ISUB, K_IAND, K_IOR, K_SWAP, K_ICMPEQ: return sp >= 2;
         K_POP, K_OUT, K_IFEQ, K_IFLT:          return sp >= 1;
         K_LDC:                                 return sb.const_cnt > 0 && sp < STACK_DEPTH;
         K_ILOAD, K_WILOAD:                     return base < LOCALS_DEPTH && sp < STACK_DEPTH;
         K_ISTORE, K_WISTORE:                   return base < LOCALS_DEPTH && sp >= 1;
         K_IINC, K_WIINC:                       return base < LOCALS_DEPTH;
         K_INVOKE: return sb.const_cnt > 0 && sb.fp < 40 && sb.ltop <= LOCALS_DEPTH - 4;
         K_IRETURN:                             return sb.fp >= FRAME_WORDS && sp >= 1;
         default:                               return 0;
      endcase
   endfunction

   // build a well-formed instruction of the given kind at the current pc
   task automatic do_instr(instr_kind_e k);
      logic [7:0]  code[$];
      logic [15:0] off, idx;
      int unsigned p, lim, maddr, nargs, nloc;
      int          must;
      p = sb.pc;
      lim = LOCALS_DEPTH - 1 - sb.frame_base();
      must = 1;
      case (k)
         K_NOP:    code = '{OPC_NOP};
         K_BIPUSH: begin code = '{OPC_BIPUSH, $urandom_range(0, 255)}; must = 2; end
         K_DUP:    code = '{OPC_DUP};
         K_IADD:   code = '{OPC_IADD};
         K_ISUB:   code = '{OPC_ISUB};
         K_IAND:   code = '{OPC_IAND};
         K_IOR:    code = '{OPC_IOR};
         K_POP:    code = '{OPC_POP};
         K_SWAP:   code = '{OPC_SWAP};
         K_IN:     code = '{OPC_IN};
         K_OUT:    code = '{OPC_OUT};
         K_IRETURN: code = '{OPC_IRETURN};
         K_GOTO, K_IFEQ, K_IFLT, K_ICMPEQ: begin
            off = $urandom_range(0, 4080) - p;
            code = '{(k == K_GOTO) ? OPC_GOTO : (k == K_IFEQ) ? OPC_IFEQ :
                     (k == K_IFLT) ? OPC_IFLT : OPC_ICMPEQ, off[15:8], off[7:0]};
            must = 3;
         end
         K_LDC: begin
            idx = $urandom_range(0, sb.const_cnt - 1);
            if (!sb.const_seen[idx]) send(make_beat(REQ_LOAD_CONST, idx, $urandom()));
            code = '{OPC_LDC_W, idx[15:8], idx[7:0]};
            must = 3;
         end
         K_ILOAD, K_ISTORE, K_IINC: begin
            idx = $urandom_range(0, (lim < 255) ? lim : 255);
            code = '{(k == K_ILOAD) ? OPC_ILOAD : (k == K_ISTORE) ? OPC_ISTORE : OPC_IINC,
                     idx[7:0], $urandom_range(0, 255)};
            must = (k == K_IINC) ? 3 : 2;
         end
         K_WILOAD, K_WISTORE, K_WIINC: begin
            idx = $urandom_range(0, lim);
            code = '{OPC_WIDE, (k == K_WILOAD) ? OPC_ILOAD : (k == K_WISTORE) ? OPC_ISTORE :
                     OPC_IINC, idx[15:8], idx[7:0], $urandom_range(0, 255)};
            must = (k == K_WIINC) ? 5 : 4;
         end
         K_INVOKE: begin
            idx = $urandom_range(0, sb.const_cnt - 1);
            do maddr = $urandom_range(0, 4076);
            while (maddr + 3 >= p && maddr <= p + 2);
            nargs = $urandom_range(0, (sb.sp < 3) ? sb.sp : 3);
            nloc = $urandom_range(0, 3);
            if (sb.ltop + nargs + nloc > LOCALS_DEPTH) nloc = 0;
            send(make_beat(REQ_LOAD_CONST, idx, maddr));
            send(make_beat(REQ_LOAD_TEXT, maddr, 0));
            send(make_beat(REQ_LOAD_TEXT, maddr + 1, nargs));
            send(make_beat(REQ_LOAD_TEXT, maddr + 2, 0));
            send(make_beat(REQ_LOAD_TEXT, maddr + 3, nloc));
            code = '{OPC_INVOKE, idx[15:8], idx[7:0]};
            must = 3;
         end
         default: code = '{OPC_NOP};
      endcase
      place_and_run(code, must);
   endtask

   // stack kept shallow, frames unwound now and then
   task automatic random_instr();
      instr_kind_e k;
      bit          ok;
      do begin
         k = instr_kind_e'($urandom_range(0, K_IRETURN));
         ok = can_run(k);
         if (ok && sb.sp > 16 && k inside {K_BIPUSH, K_DUP, K_IN, K_LDC, K_ILOAD, K_WILOAD})
            ok = $urandom_range(0, 3) == 0;
         if (ok && k == K_INVOKE && sb.fp > 12) ok = $urandom_range(0, 3) == 0;
      end while (!ok);
      do_instr(k);
   endtask

   task automatic noise_item();
      case ($urandom_range(0, 2))
         0: send(make_beat(2'd3, $urandom_range(0, 4095), $urandom()));
         1: send(make_beat(REQ_LOAD_CONST, $urandom_range(0, 4095), $urandom()));
         default: send(make_beat(REQ_LOAD_TEXT, $urandom_range(0, 4095), $urandom()));
      endcase
   endtask

   // stop the machine by one of its terminal cases
   task automatic stop_machine();
      logic [7:0]  b;
      logic [15:0] idx;
      wait_drained();
      case ($urandom_range(0, 7))
         0: place_and_run('{OPC_HALT}, 1);
         1: place_and_run('{OPC_ERR}, 1);
         2: begin
            do b = $urandom_range(0, 255);
            while (b inside {OPC_NOP, OPC_BIPUSH, OPC_LDC_W, OPC_ILOAD, OPC_ISTORE, OPC_POP,
                             OPC_DUP, OPC_SWAP, OPC_IADD, OPC_ISUB, OPC_IAND, OPC_IINC,
                             OPC_IFEQ, OPC_IFLT, OPC_ICMPEQ, OPC_GOTO, OPC_IRETURN, OPC_IOR,
                             OPC_INVOKE, OPC_WIDE, OPC_IN, OPC_OUT, OPC_ERR, OPC_HALT});
            place_and_run('{b}, 1);
         end
         3: begin
            do b = $urandom_range(0, 255);
            while (b inside {OPC_ILOAD, OPC_ISTORE, OPC_IINC});
            place_and_run('{OPC_WIDE, b, 0, 0, 0}, 2);
         end
         4: begin
            idx = sb.const_cnt + $urandom_range(0, 3);
            place_and_run('{OPC_LDC_W, idx[15:8], idx[7:0]}, 3);
         end
         5: begin
            while (sb.sp > 0) do_instr(K_POP);
            place_and_run('{OPC_POP}, 1);
         end
         6: begin
            while (sb.fp >= FRAME_WORDS) begin
               if (sb.sp == 0) do_instr(K_BIPUSH);
               do_instr(K_IRETURN);
            end
            place_and_run('{OPC_IRETURN}, 1);
         end
         default: begin
            write_reg(CSR_PROGRAM_LENGTH, sb.pc);
            send(make_beat(REQ_EXECUTE, 0, 0));
         end
      endcase
      // machine stays stopped
      send(make_beat(REQ_EXECUTE, 0, $urandom()));
      send(make_beat(REQ_LOAD_TEXT, $urandom_range(0, 4095), $urandom()));
      send(make_beat(REQ_EXECUTE, 0, $urandom()));
      wait_drained();
      write_reg(CSR_PROGRAM_LENGTH, 0);
      write_reg(CSR_CONSTANT_COUNT, 0);
      send(make_beat(REQ_EXECUTE, 0, $urandom()));
   endtask

   // response side: random stalls, one long hold-off
   initial begin
      rsp_beat_t a;
      int        gap;
      rsp_ch.ready <= 0;
      forever begin
         if (results_seen == 400) begin
            rsp_ch.ready <= 0;
            repeat (300) @(posedge clock);
         end
         gap = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_ch.ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         a.out_valid = rsp_ch.out_valid;
         a.out_char = rsp_ch.out_char;
         a.next_pc = rsp_ch.next_pc;
         a.halted = rsp_ch.halted;
         a.status = rsp_ch.status;
         a.top_value = rsp_ch.top_value;
         a.stack_count = rsp_ch.stack_count;
         sb.check_result(a);
         results_seen++;
      end
   end

   // stimulus
   initial begin
      instr_kind_e seq[$];
      sb = new();
      reset <= 1;
      req_ch.valid <= 0;
      req_ch.op <= REQ_LOAD_TEXT;
      req_ch.load_address <= '0;
      req_ch.load_value <= '0;
      req_ch.in_char <= '0;
      req_ch.in_eof <= 0;
      csr_ch.valid <= 0;
      csr_ch.index <= CSR_PROGRAM_LENGTH;
      csr_ch.data <= '0;
      repeat (8) @(posedge clock);
      reset <= 0;

      write_reg(CSR_PROGRAM_LENGTH, TEXT_DEPTH);
      write_reg(CSR_CONSTANT_COUNT, CONST_DEPTH);

      // every instruction kind at least once, plus ignored beats
      seq = '{K_BIPUSH, K_BIPUSH, K_IADD, K_BIPUSH, K_ISUB, K_DUP, K_IAND, K_BIPUSH, K_IOR,
              K_BIPUSH, K_SWAP, K_POP, K_IN, K_OUT, K_ISTORE, K_ILOAD, K_IINC, K_WISTORE,
              K_WILOAD, K_WIINC, K_LDC, K_IFEQ, K_IFLT, K_ICMPEQ, K_GOTO, K_INVOKE,
              K_IRETURN, K_NOP};
      foreach (seq[i]) begin
         while (!can_run(seq[i])) do_instr((sb.sp < 2) ? K_BIPUSH : K_POP);
         do_instr(seq[i]);
      end
      send(make_beat(2'd3, 4095, $urandom()));
      send(make_beat(REQ_LOAD_CONST, 4095, $urandom()));

      // random programs; settings change between phases
      while (items_sent < 1150) begin
         if ($urandom_range(0, 9) == 0) noise_item();
         else random_instr();
         if (items_sent % 150 < 5 && sb.pending.size() > 0 && $urandom_range(0, 3) == 0) begin
            wait_drained();
            write_reg(CSR_PROGRAM_LENGTH, $urandom_range(4088, TEXT_DEPTH));
            case ($urandom_range(0, 3))
               0: write_reg(CSR_CONSTANT_COUNT, 0);
               1: write_reg(CSR_CONSTANT_COUNT, 1);
               2: write_reg(CSR_CONSTANT_COUNT, CONST_DEPTH);
               default: write_reg(CSR_CONSTANT_COUNT, $urandom_range(1, CONST_DEPTH));
            endcase
         end
      end
      stop_machine();

      req_ch.valid <= 0;
      wait_drained();
      repeat (40) @(posedge clock);
      $display("covered %0d request beats, %0d instructions run, %0d responses checked",
               items_sent, sb.executed, sb.checked);
      $display("frame depth %0d, locals top %0d, final status halted=%0d at pc %0d",
               sb.fp, sb.ltop, sb.done, sb.pc);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/ijvm_pkg.sv
rtl/ijvm_if.sv
rtl/ijvm_ram.sv
rtl/ijvm_stack_machine_core.sv
sim/ijvm_stack_machine_core_tb.sv
